// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the collision block.
// Uses i_clk and i_rst_n of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define CCR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ccr_pkg.sv =====
// Constants of the circle collision resolver: wall codes, margin, register map.
// No dependencies.
package ccr_pkg;

    localparam int FRAC_BITS   = 4;
    localparam int WALL_MARGIN = 5 << FRAC_BITS;  // 5.0 in Q12.4
    localparam int ARENA_RESET = 16000;

    localparam logic [2:0] HIT_NONE   = 3'd0;
    localparam logic [2:0] HIT_RIGHT  = 3'd1;
    localparam logic [2:0] HIT_LEFT   = 3'd2;
    localparam logic [2:0] HIT_BOTTOM = 3'd3;
    localparam logic [2:0] HIT_TOP    = 3'd4;

    // Register index as seen in paddr[2].
    localparam logic REG_ARENA_WIDTH  = 1'b0;
    localparam logic REG_ARENA_HEIGHT = 1'b1;

endpackage

// ===== rtl/core/circle_collision_resolve_top.sv =====
// Circle collision resolver: wall and pair tests on Q12.4 circles, fully pipelined.
// Depends on ccr_pkg and assert_macros.svh.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall with one port per request field.
//   A beat is taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall; one result beat per request.
//   Configuration: APB-style port, arena_width at 0x0, arena_height at 0x4.
//   Write the arena size only while no request is in flight.
// Pipeline: a bit-per-stage square root (COORD_BITS + 1 stages) followed by
//   two bit-per-stage dividers (COORD_BITS + 1 stages), plus squaring,
//   product and saturation stages.
// Throughput: one request per cycle while the output beat is not held.
// Reset: flushes every valid bit and loads both arena registers with 16000.
// Stall: when the output beat is held, the whole pipeline freezes and
//   o_in_stall rises in the same cycle; nothing is dropped or repeated.
`include "assert_macros.svh"

module circle_collision_resolve_top
    import ccr_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_mobile_x,
    input  logic [COORD_BITS-1:0] i_mobile_y,
    input  logic [COORD_BITS-1:0] i_mobile_radius,
    input  logic [COORD_BITS-1:0] i_other_x,
    input  logic [COORD_BITS-1:0] i_other_y,
    input  logic [COORD_BITS-1:0] i_other_radius,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_wall_hit,
    output logic                  o_overlap,
    output logic [COORD_BITS-1:0] o_new_x,
    output logic [COORD_BITS-1:0] o_new_y,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int N   = COORD_BITS;
    localparam int SB  = N + 1;          // root bits
    localparam int QB  = N + 1;          // quotient bits
    localparam int NW  = 2 * N + 2;      // numerator and radicand width
    localparam int SW  = N + 3;          // signed width for saturation
    localparam int SQ0 = 3;              // first root stage
    localparam int MS  = SQ0 + SB;       // product stage
    localparam int AS  = MS + 1;         // rounding add stage
    localparam int DS  = AS + 1;         // first divide stage
    localparam int FS  = DS + QB;        // final stage
    localparam int NS  = FS + 1;

    localparam logic [31:0] RST32 = 32'(ARENA_RESET);
    localparam logic [N:0]  MARGIN = (N + 1)'(WALL_MARGIN);

    typedef struct packed {
        logic          req;
        logic [2:0]    hit;
        logic          ovl;
        logic [N-1:0]  nx;
        logic [N-1:0]  ny;
        logic [N-1:0]  mx;
        logic [N-1:0]  my;
        logic          px;
        logic          py;
        logic [N-1:0]  adx;
        logic [N-1:0]  ady;
        logic [N:0]    rsum;
        logic          zero;
        logic [2*N-1:0] sqx;
        logic [2*N-1:0] sqy;
        logic [NW-1:0] rsq;
        logic [NW-1:0] rad;
        logic [SB+1:0] srem;
        logic [SB-1:0] root;
        logic [NW-1:0] numx;
        logic [NW-1:0] numy;
        logic [SB:0]   dremx;
        logic [SB:0]   dremy;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
    } t_stage;

    function automatic logic [N-1:0] sat(input logic signed [SW-1:0] v);
        logic [N-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({3'b000, {N{1'b1}}})) begin
            res = '1;
        end else begin
            res = v[N-1:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [N-1:0] r_arena_w, r_arena_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_w <= RST32[N-1:0];
            r_arena_h <= RST32[N-1:0];
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_ARENA_WIDTH:  r_arena_w <= pwdata[N-1:0];
                REG_ARENA_HEIGHT: r_arena_h <= pwdata[N-1:0];
                default:          r_arena_w <= r_arena_w;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ARENA_HEIGHT) ? 32'(r_arena_h) : 32'(r_arena_w);

    // ---------------------------------------------------------------
    // Pipeline control: freeze everything while the output beat is held
    // ---------------------------------------------------------------
    t_stage r_st [NS];
    t_stage n_st [NS];
    logic [NS-1:0] r_vld;
    logic          w_adv;

    assign w_adv      = !(r_vld[NS-1] && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Stage 0: wall tests resolved outright; pair differences prepared.
    always_comb begin
        logic [N:0] sum_x, sum_y;
        n_st[0]      = '0;
        n_st[0].req  = i_req_type;
        n_st[0].mx   = i_mobile_x;
        n_st[0].my   = i_mobile_y;
        n_st[0].nx   = i_mobile_x;
        n_st[0].ny   = i_mobile_y;
        n_st[0].hit  = HIT_NONE;
        n_st[0].px   = i_mobile_x >= i_other_x;
        n_st[0].py   = i_mobile_y >= i_other_y;
        n_st[0].adx  = n_st[0].px ? i_mobile_x - i_other_x : i_other_x - i_mobile_x;
        n_st[0].ady  = n_st[0].py ? i_mobile_y - i_other_y : i_other_y - i_mobile_y;
        n_st[0].rsum = {1'b0, i_mobile_radius} + {1'b0, i_other_radius};
        sum_x = {1'b0, i_mobile_x} + {1'b0, i_mobile_radius};
        sum_y = {1'b0, i_mobile_y} + {1'b0, i_mobile_radius};
        if (!i_req_type) begin
            // Priority: right, left, bottom, top.
            priority if (sum_x >= {1'b0, r_arena_w}) begin
                n_st[0].hit = HIT_RIGHT;
                n_st[0].nx  = sat($signed({3'b000, r_arena_w})
                                  - $signed({2'b00, {1'b0, i_mobile_radius} + MARGIN}));
            end else if (i_mobile_x <= i_mobile_radius) begin
                n_st[0].hit = HIT_LEFT;
                n_st[0].nx  = sat($signed({2'b00, {1'b0, i_mobile_radius} + MARGIN}));
            end else if (sum_y >= {1'b0, r_arena_h}) begin
                n_st[0].hit = HIT_BOTTOM;
                n_st[0].ny  = sat($signed({3'b000, r_arena_h})
                                  - $signed({2'b00, {1'b0, i_mobile_radius} + MARGIN}));
            end else if (i_mobile_y <= i_mobile_radius) begin
                n_st[0].hit = HIT_TOP;
                n_st[0].ny  = sat($signed({2'b00, {1'b0, i_mobile_radius} + MARGIN}));
            end else begin
                n_st[0].hit = HIT_NONE;
            end
            n_st[0].ovl = n_st[0].hit != HIT_NONE;
        end
    end

    // Stage 1: squares.
    always_comb begin
        n_st[1]     = r_st[0];
        n_st[1].sqx = r_st[0].adx * r_st[0].adx;
        n_st[1].sqy = r_st[0].ady * r_st[0].ady;
        n_st[1].rsq = NW'(r_st[0].rsum * r_st[0].rsum);
    end

    // Stage 2: distance squared, overlap test, seed the root.
    always_comb begin
        n_st[2]      = r_st[1];
        n_st[2].rad  = NW'({1'b0, r_st[1].sqx}) + NW'({1'b0, r_st[1].sqy});
        n_st[2].zero = n_st[2].rad == '0;
        n_st[2].srem = '0;
        n_st[2].root = '0;
        if (r_st[1].req) begin
            n_st[2].ovl = n_st[2].rad <= r_st[1].rsq;
        end
    end

    // Root stages: one result bit per stage.
    for (genvar j = 0; j < SB; j++) begin : g_sqrt
        always_comb begin
            logic [SB+2:0] rin, trial;
            n_st[SQ0+j] = r_st[SQ0+j-1];
            rin   = {r_st[SQ0+j-1].srem[SB:0], r_st[SQ0+j-1].rad[2*(SB-1-j) +: 2]};
            trial = {1'b0, r_st[SQ0+j-1].root, 2'b01};
            if (rin >= trial) begin
                n_st[SQ0+j].srem = (SB + 2)'(rin - trial);
                n_st[SQ0+j].root = {r_st[SQ0+j-1].root[SB-2:0], 1'b1};
            end else begin
                n_st[SQ0+j].srem = (SB + 2)'(rin);
                n_st[SQ0+j].root = {r_st[SQ0+j-1].root[SB-2:0], 1'b0};
            end
        end
    end

    // Product stage: push length times each axis distance.
    always_comb begin
        logic [SB-1:0] move;
        n_st[MS]      = r_st[MS-1];
        move          = r_st[MS-1].rsum - r_st[MS-1].root;
        n_st[MS].numx = NW'(r_st[MS-1].adx * move);
        n_st[MS].numy = NW'(r_st[MS-1].ady * move);
    end

    // Rounding stage: add half the divisor, seed the dividers.
    always_comb begin
        n_st[AS]       = r_st[MS];
        n_st[AS].numx  = r_st[MS].numx + NW'(r_st[MS].root >> 1);
        n_st[AS].numy  = r_st[MS].numy + NW'(r_st[MS].root >> 1);
        n_st[AS].dremx = {1'b0, n_st[AS].numx[NW-1:QB]};
        n_st[AS].dremy = {1'b0, n_st[AS].numy[NW-1:QB]};
        n_st[AS].qx    = '0;
        n_st[AS].qy    = '0;
    end

    // Divide stages: one quotient bit per stage on each axis.
    for (genvar j = 0; j < QB; j++) begin : g_div
        always_comb begin
            logic [SB:0] tx, ty, dv;
            n_st[DS+j] = r_st[DS+j-1];
            dv = {1'b0, r_st[DS+j-1].root};
            tx = {r_st[DS+j-1].dremx[SB-1:0], r_st[DS+j-1].numx[QB-1-j]};
            ty = {r_st[DS+j-1].dremy[SB-1:0], r_st[DS+j-1].numy[QB-1-j]};
            if (tx >= dv) begin
                n_st[DS+j].dremx = tx - dv;
                n_st[DS+j].qx    = {r_st[DS+j-1].qx[QB-2:0], 1'b1};
            end else begin
                n_st[DS+j].dremx = tx;
                n_st[DS+j].qx    = {r_st[DS+j-1].qx[QB-2:0], 1'b0};
            end
            if (ty >= dv) begin
                n_st[DS+j].dremy = ty - dv;
                n_st[DS+j].qy    = {r_st[DS+j-1].qy[QB-2:0], 1'b1};
            end else begin
                n_st[DS+j].dremy = ty;
                n_st[DS+j].qy    = {r_st[DS+j-1].qy[QB-2:0], 1'b0};
            end
        end
    end

    // Final stage: apply the push with its sign and saturate.
    always_comb begin
        logic signed [SW-1:0] mxs, mys, qxs, qys;
        n_st[FS] = r_st[FS-1];
        mxs = $signed({3'b000, r_st[FS-1].mx});
        mys = $signed({3'b000, r_st[FS-1].my});
        qxs = $signed({2'b00, r_st[FS-1].qx});
        qys = $signed({2'b00, r_st[FS-1].qy});
        if (r_st[FS-1].req && r_st[FS-1].ovl) begin
            if (r_st[FS-1].zero) begin
                // Coincident centres: push along +x by the radius sum.
                n_st[FS].nx = sat(mxs + $signed({2'b00, r_st[FS-1].rsum}));
            end else begin
                n_st[FS].nx = sat(r_st[FS-1].px ? mxs + qxs : mxs - qxs);
                n_st[FS].ny = sat(r_st[FS-1].py ? mys + qys : mys - qys);
            end
        end
    end

    assign o_out_valid = r_vld[NS-1];
    assign o_wall_hit  = r_st[NS-1].hit;
    assign o_overlap   = r_st[NS-1].ovl;
    assign o_new_x     = r_st[NS-1].nx;
    assign o_new_y     = r_st[NS-1].ny;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `CCR_ASSERT(a_pair_no_wall, o_out_valid && r_st[NS-1].req |-> o_wall_hit == HIT_NONE,
        "pair result carries a wall code")
    `CCR_ASSERT(a_wall_ovl, o_out_valid && !r_st[NS-1].req |-> o_overlap == (o_wall_hit != HIT_NONE),
        "wall result overlap disagrees with wall code")
    `CCR_ASSERT_NEVER(a_stall_no_out, o_in_stall && !o_out_valid,
        "input stalled without a held result")

endmodule
